/* src/cftd_pkg.sv */
// Shared types and constants for the checked frame throttle decoder.
package cftd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEVEL_W = 16;
    localparam int unsigned CHECK_W = 16;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] MODE_ACCEL   = 8'h41;  // 'A'
    localparam logic [BYTE_W-1:0] MODE_BUTTONS = 8'h42;  // 'B'

    localparam logic [BYTE_W-1:0] RST_THRESHOLD   = 8'd50;
    localparam logic [BYTE_W-1:0] RST_GAIN_BELOW  = 8'd150;
    localparam logic [BYTE_W-1:0] RST_GAIN_ABOVE  = 8'd100;
    localparam logic [BYTE_W-1:0] RST_BUTTON_GAIN = 8'd100;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_BELOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_ABOVE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_GAIN = 2'd3;

    localparam logic [BYTE_W:0] MOD_255 = 9'd255;

    typedef struct packed {
        logic [BYTE_W-1:0] threshold;
        logic [BYTE_W-1:0] gain_below;
        logic [BYTE_W-1:0] gain_above;
        logic [BYTE_W-1:0] button_gain;
    } t_cfg;

    typedef enum logic [1:0] {
        MK_NONE,
        MK_ACCEL,
        MK_BUTTONS
    } t_mode_kind;

    // Everything the result stage needs when the last byte of a frame moves
    typedef struct packed {
        logic               done;
        logic [BYTE_W-1:0]  mode;
        t_mode_kind         kind;
        logic [LEVEL_W-1:0] product;
        logic [CHECK_W-1:0] received;
        logic [CHECK_W-1:0] computed;
    } t_frame_end;

    // (a + b) mod 255 for a <= 254, b <= 255; one subtract is enough
    function automatic logic [BYTE_W-1:0] add_mod255(input logic [BYTE_W-1:0] a,
                                                     input logic [BYTE_W-1:0] b);
        logic [BYTE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= MOD_255) begin
            s = s - MOD_255;
        end
        return s[BYTE_W-1:0];
    endfunction

endpackage

/* src/cftd_cfg_regs.sv */
// Configuration register file: threshold and gains.
module cftd_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [cftd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cftd_pkg::BYTE_W-1:0]   i_cfg_wdata,
    output cftd_pkg::t_cfg                o_cfg
);
    import cftd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold   <= RST_THRESHOLD;
            r_cfg.gain_below  <= RST_GAIN_BELOW;
            r_cfg.gain_above  <= RST_GAIN_ABOVE;
            r_cfg.button_gain <= RST_BUTTON_GAIN;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_THRESHOLD:   r_cfg.threshold   <= i_cfg_wdata;
                CFG_GAIN_BELOW:  r_cfg.gain_below  <= i_cfg_wdata;
                CFG_GAIN_ABOVE:  r_cfg.gain_above  <= i_cfg_wdata;
                CFG_BUTTON_GAIN: r_cfg.button_gain <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* src/cftd_frame_acc.sv */
// Input register and per-byte frame tracking: position, Fletcher sums, held bytes.
module cftd_frame_acc #(
    parameter int unsigned FRAME_BYTES = 9
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [cftd_pkg::BYTE_W-1:0] i_rx_byte,
    input  cftd_pkg::t_cfg              i_cfg,
    input  logic                        i_out_free,
    output cftd_pkg::t_frame_end        o_frame_end
);
    import cftd_pkg::*;

    localparam int unsigned POS_W = $clog2(FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_LAST     = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] POS_CHECK_HI = POS_W'(FRAME_BYTES - 2);
    localparam logic [POS_W-1:0] POS_THROTTLE = POS_W'(FRAME_BYTES - 3);

    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_in_byte;
    logic [POS_W-1:0]   r_pos;
    logic [BYTE_W-1:0]  r_sum_a;
    logic [BYTE_W-1:0]  r_sum_b;
    logic [BYTE_W-1:0]  r_held_mode;
    logic [BYTE_W-1:0]  r_check_hi;
    logic [LEVEL_W-1:0] r_product;
    t_mode_kind         r_kind;

    logic               is_last;
    logic               step;
    logic [BYTE_W-1:0]  add;
    logic [BYTE_W-1:0]  n_sum_a;
    logic [BYTE_W-1:0]  n_sum_b;
    logic [BYTE_W-1:0]  gain;
    t_mode_kind         n_kind;
    logic [LEVEL_W-1:0] n_product;

    assign is_last    = (r_pos == POS_LAST);
    // the last byte of a frame only moves when the result slot can take it
    assign step       = r_in_valid && (!is_last || i_out_free);
    assign o_in_stall = r_in_valid && !step;

    assign add     = (r_pos < POS_CHECK_HI) ? r_in_byte : '0;
    assign n_sum_a = add_mod255(r_sum_a, add);
    assign n_sum_b = add_mod255(n_sum_a, r_sum_b);

    // throttle product is formed when the throttle word passes; mode is already held
    always_comb begin
        n_kind = MK_NONE;
        gain   = i_cfg.button_gain;
        if (r_held_mode == MODE_ACCEL) begin
            n_kind = MK_ACCEL;
            gain   = (r_in_byte < i_cfg.threshold) ? i_cfg.gain_below : i_cfg.gain_above;
        end else if (r_held_mode == MODE_BUTTONS) begin
            n_kind = MK_BUTTONS;
        end
        n_product = LEVEL_W'({8'd0, r_in_byte} * {8'd0, gain});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_sum_a     <= '0;
            r_sum_b     <= '0;
            r_held_mode <= '0;
            r_check_hi  <= '0;
            r_product   <= '0;
            r_kind      <= MK_NONE;
        end else if (step) begin
            if (is_last) begin
                r_pos   <= '0;
                r_sum_a <= '0;
                r_sum_b <= '0;
            end else begin
                r_pos   <= r_pos + 1'b1;
                r_sum_a <= n_sum_a;
                r_sum_b <= n_sum_b;
            end
            if (r_pos == '0) begin
                r_held_mode <= r_in_byte;
            end
            if (r_pos == POS_THROTTLE) begin
                r_product <= n_product;
                r_kind    <= n_kind;
            end
            if (r_pos == POS_CHECK_HI) begin
                r_check_hi <= r_in_byte;
            end
        end
    end

    assign o_frame_end.done     = step && is_last;
    assign o_frame_end.mode     = r_held_mode;
    assign o_frame_end.kind     = r_kind;
    assign o_frame_end.product  = r_product;
    assign o_frame_end.received = {r_check_hi, r_in_byte};
    assign o_frame_end.computed = {n_sum_b, n_sum_a};

endmodule

/* src/cftd_result.sv */
// Result stage: checksum compare, throttle level register and output register.
module cftd_result (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cftd_pkg::t_frame_end         i_frame_end,
    input  logic                         i_out_stall,
    output logic                         o_out_free,
    output logic                         o_out_valid,
    output logic                         o_checksum_ok,
    output logic [cftd_pkg::BYTE_W-1:0]  o_mode_byte,
    output logic                         o_throttle_written,
    output logic [cftd_pkg::LEVEL_W-1:0] o_throttle_level,
    output logic [cftd_pkg::CHECK_W-1:0] o_received_check,
    output logic [cftd_pkg::CHECK_W-1:0] o_computed_check
);
    import cftd_pkg::*;

    logic               r_out_valid;
    logic               r_ok;
    logic [BYTE_W-1:0]  r_mode;
    logic               r_written;
    logic [LEVEL_W-1:0] r_level;
    logic [CHECK_W-1:0] r_received;
    logic [CHECK_W-1:0] r_computed;

    logic               ok;
    logic               written;
    logic [LEVEL_W-1:0] n_level;

    assign o_out_free = !r_out_valid || !i_out_stall;

    assign ok      = (i_frame_end.received == i_frame_end.computed);
    assign written = ok && (i_frame_end.kind != MK_NONE);
    assign n_level = written ? i_frame_end.product : r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_level     <= '0;
        end else if (i_frame_end.done) begin
            r_out_valid <= 1'b1;
            r_level     <= n_level;
        end else if (o_out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_frame_end.done) begin
            r_ok       <= ok;
            r_mode     <= i_frame_end.mode;
            r_written  <= written;
            r_received <= i_frame_end.received;
            r_computed <= i_frame_end.computed;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_checksum_ok      = r_ok;
    assign o_mode_byte        = r_mode;
    assign o_throttle_written = r_written;
    assign o_throttle_level   = r_level;
    assign o_received_check   = r_received;
    assign o_computed_check   = r_computed;

endmodule

/* src/checked_frame_throttle_decoder.sv */
// Checked frame throttle decoder: top level.
//
// Input channel (i_in_valid / o_in_stall, i_rx_byte) takes one received byte
// per word. Bytes form fixed frames of FRAME_BYTES; byte 0 is the mode letter,
// byte FRAME_BYTES-3 the throttle byte, the last two the Fletcher-16 check,
// high byte first. After the last byte of a frame one word leaves on the
// output channel (o_out_valid / i_out_stall) carrying the check result, mode,
// both checksums and the throttle level; bytes inside a frame give nothing.
// Throughput is one byte per cycle while o_in_stall is low. Each byte passes
// through the input register; a frame's result word is loaded into the output
// register at the edge where its last byte leaves the input register.
// When the receiver stalls, the result word holds in the output register and
// bytes keep flowing until the next frame's last byte, which waits in the
// input register; then o_in_stall rises.
// Reset (synchronous, active low) clears frame position, sums, held bytes and
// the throttle level, and loads the configuration defaults. Configuration
// registers are written through i_cfg_wr_en / i_cfg_idx / i_cfg_wdata.
module checked_frame_throttle_decoder #(
    parameter int unsigned FRAME_BYTES = 9
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [cftd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cftd_pkg::BYTE_W-1:0]    i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [cftd_pkg::BYTE_W-1:0]    i_rx_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_checksum_ok,
    output logic [cftd_pkg::BYTE_W-1:0]    o_mode_byte,
    output logic                           o_throttle_written,
    output logic [cftd_pkg::LEVEL_W-1:0]   o_throttle_level,
    output logic [cftd_pkg::CHECK_W-1:0]   o_received_check,
    output logic [cftd_pkg::CHECK_W-1:0]   o_computed_check
);
    import cftd_pkg::*;

    t_cfg       cfg;
    t_frame_end frame_end;
    logic       out_free;

    cftd_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    cftd_frame_acc #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_frame_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_rx_byte   (i_rx_byte),
        .i_cfg       (cfg),
        .i_out_free  (out_free),
        .o_frame_end (frame_end)
    );

    cftd_result u_result (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_frame_end        (frame_end),
        .i_out_stall        (i_out_stall),
        .o_out_free         (out_free),
        .o_out_valid        (o_out_valid),
        .o_checksum_ok      (o_checksum_ok),
        .o_mode_byte        (o_mode_byte),
        .o_throttle_written (o_throttle_written),
        .o_throttle_level   (o_throttle_level),
        .o_received_check   (o_received_check),
        .o_computed_check   (o_computed_check)
    );

endmodule

/* tb/tb_checked_frame_throttle_decoder.sv */
// Testbench for the checked frame throttle decoder: frames with random and broken checks.
`timescale 1ns / 100ps

module tb_checked_frame_throttle_decoder;

    import cftd_pkg::*;

    localparam int FRAME_LEN     = 9;
    localparam int FRAMES_PER_SET = 12;
    localparam int CYCLE_LIMIT   = 200000;

    typedef logic [BYTE_W-1:0] t_frame_bytes [FRAME_LEN];

    typedef struct {
        logic               ok;
        logic [BYTE_W-1:0]  mode;
        logic               written;
        logic [LEVEL_W-1:0] level;
        logic [CHECK_W-1:0] received;
        logic [CHECK_W-1:0] computed;
    } t_frame_result;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx    = '0;
    logic [BYTE_W-1:0]    i_cfg_wdata  = '0;
    logic                 i_in_valid   = 1'b0;
    logic [BYTE_W-1:0]    i_rx_byte    = '0;
    logic                 i_out_stall  = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic                 o_checksum_ok;
    logic [BYTE_W-1:0]    o_mode_byte;
    logic                 o_throttle_written;
    logic [LEVEL_W-1:0]   o_throttle_level;
    logic [CHECK_W-1:0]   o_received_check;
    logic [CHECK_W-1:0]   o_computed_check;

    // predictor state and its copy of the registers
    logic [3:0]         frame_pos   = '0;
    logic [BYTE_W-1:0]  sum_lo      = '0;
    logic [BYTE_W-1:0]  sum_hi      = '0;
    logic [BYTE_W-1:0]  held_mode   = '0;
    logic [BYTE_W-1:0]  held_thr    = '0;
    logic [BYTE_W-1:0]  held_chk_hi = '0;
    logic [LEVEL_W-1:0] level       = '0;
    t_cfg               gains_cfg   = '{RST_THRESHOLD, RST_GAIN_BELOW,
                                        RST_GAIN_ABOVE, RST_BUTTON_GAIN};

    logic [BYTE_W-1:0] bytes_to_send [$];
    t_frame_result     frame_results_due [$];
    int                send_gap   = 0;
    int                stall_left = 0;
    bit                calm       = 1'b0;
    int                mismatches = 0;
    int                cycles     = 0;

    checked_frame_throttle_decoder #(
        .FRAME_BYTES(FRAME_LEN)
    ) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_rx_byte         (i_rx_byte),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_checksum_ok     (o_checksum_ok),
        .o_mode_byte       (o_mode_byte),
        .o_throttle_written(o_throttle_written),
        .o_throttle_level  (o_throttle_level),
        .o_received_check  (o_received_check),
        .o_computed_check  (o_computed_check)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [BYTE_W-1:0] add255(input logic [BYTE_W-1:0] a,
                                                 input logic [BYTE_W-1:0] b);
        int unsigned s;
        s = a;
        s = s + b;
        return BYTE_W'(s % 255);
    endfunction

    // Advance the frame decoder by one accepted byte; queue a result at frame end
    task automatic decode_rx_byte(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] add;
        logic [BYTE_W-1:0] na;
        logic [BYTE_W-1:0] nb;
        logic [BYTE_W-1:0] gain;
        t_frame_result     r;
        add = (frame_pos < FRAME_LEN - 2) ? b : '0;
        na = add255(sum_lo, add);
        nb = add255(na, sum_hi);
        if (frame_pos == 0) begin
            held_mode = b;
        end
        if (frame_pos == FRAME_LEN - 3) begin
            held_thr = b;
        end
        if (frame_pos == FRAME_LEN - 2) begin
            held_chk_hi = b;
        end
        if (frame_pos < FRAME_LEN - 1) begin
            sum_lo = na;
            sum_hi = nb;
            frame_pos = frame_pos + 1'b1;
        end else begin
            r.received = {held_chk_hi, b};
            r.computed = {nb, na};
            r.ok = (r.received == r.computed);
            r.written = 1'b0;
            if (r.ok && (held_mode == MODE_ACCEL || held_mode == MODE_BUTTONS)) begin
                if (held_mode == MODE_BUTTONS) begin
                    gain = gains_cfg.button_gain;
                end else if (held_thr < gains_cfg.threshold) begin
                    gain = gains_cfg.gain_below;
                end else begin
                    gain = gains_cfg.gain_above;
                end
                level = LEVEL_W'(32'(held_thr) * 32'(gain));
                r.written = 1'b1;
            end
            r.mode = held_mode;
            r.level = level;
            frame_results_due.push_back(r);
            frame_pos = '0;
            sum_lo = '0;
            sum_hi = '0;
        end
    endtask

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %h actual %h", $time, what, want, got);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (send_gap > 0) begin
                i_in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (bytes_to_send.size() > 0) begin
                i_in_valid <= 1'b1;
                i_rx_byte <= bytes_to_send.pop_front();
                if (!calm && $urandom_range(0, 5) == 0) begin
                    send_gap <= $urandom_range(1, 4);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor: predict on accepted bytes, compare accepted result words
    always @(posedge i_clk) begin
        t_frame_result want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                decode_rx_byte(i_rx_byte);
            end
            if (o_out_valid && !i_out_stall) begin
                if (frame_results_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected word, expected none actual check %h/%h",
                             $time, o_received_check, o_computed_check);
                end else begin
                    want = frame_results_due.pop_front();
                    check_field("checksum_ok", 16'(want.ok), 16'(o_checksum_ok));
                    check_field("mode_byte", 16'(want.mode), 16'(o_mode_byte));
                    check_field("throttle_written", 16'(want.written),
                                16'(o_throttle_written));
                    check_field("throttle_level", want.level, o_throttle_level);
                    check_field("received_check", want.received, o_received_check);
                    check_field("computed_check", want.computed, o_computed_check);
                end
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                i_out_stall <= 1'b1;
                stall_left <= $urandom_range(0, 3);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= value;
        case (idx)
            CFG_THRESHOLD:   gains_cfg.threshold = value;
            CFG_GAIN_BELOW:  gains_cfg.gain_below = value;
            CFG_GAIN_ABOVE:  gains_cfg.gain_above = value;
            CFG_BUTTON_GAIN: gains_cfg.button_gain = value;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic apply_config(input logic [BYTE_W-1:0] thr, input logic [BYTE_W-1:0] gb,
                                input logic [BYTE_W-1:0] ga, input logic [BYTE_W-1:0] bg);
        set_reg(CFG_THRESHOLD, thr);
        set_reg(CFG_GAIN_BELOW, gb);
        set_reg(CFG_GAIN_ABOVE, ga);
        set_reg(CFG_BUTTON_GAIN, bg);
    endtask

    // Queue one frame; the check covers bytes 0..FRAME_LEN-3 plus two zero bytes
    task automatic queue_frame(input logic [BYTE_W-1:0] mode, input logic [BYTE_W-1:0] thr,
                               input bit corrupt);
        t_frame_bytes      fb;
        logic [BYTE_W-1:0] sa;
        logic [BYTE_W-1:0] sb;
        logic [15:0]       chk;
        sa = '0;
        sb = '0;
        for (int i = 0; i < FRAME_LEN - 2; i++) begin
            fb[i] = (i == 0) ? mode : (i == FRAME_LEN - 3) ? thr : BYTE_W'($urandom_range(0, 255));
            sa = add255(sa, fb[i]);
            sb = add255(sb, sa);
        end
        sb = add255(sb, sa);
        sb = add255(sb, sa);
        chk = {sb, sa};
        if (corrupt) begin
            chk = chk ^ 16'($urandom_range(1, 65535));
        end
        fb[FRAME_LEN-2] = chk[15:8];
        fb[FRAME_LEN-1] = chk[7:0];
        for (int i = 0; i < FRAME_LEN; i++) begin
            bytes_to_send.push_back(fb[i]);
        end
    endtask

    task automatic queue_random_frames(input int count);
        logic [BYTE_W-1:0] mode;
        logic [BYTE_W-1:0] thr;
        int                pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 19);
            mode = (pick < 8) ? MODE_ACCEL : (pick < 15) ? MODE_BUTTONS
                                                         : BYTE_W'($urandom_range(0, 255));
            case ($urandom_range(0, 6))
                0: thr = 8'h00;
                1: thr = 8'hff;
                2: thr = gains_cfg.threshold - 1'b1;
                3: thr = gains_cfg.threshold;
                4: thr = gains_cfg.threshold + 1'b1;
                default: thr = BYTE_W'($urandom_range(0, 255));
            endcase
            queue_frame(mode, thr, $urandom_range(0, 4) == 0);
        end
    endtask

    // wait until every queued byte is sent and every due result word is taken; leave margin
    task automatic wait_idle();
        while (bytes_to_send.size() != 0 || i_in_valid || frame_results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // defaults: under-split accel, full-scale buttons, bad check
        queue_frame(MODE_ACCEL, 8'd49, 1'b0);
        queue_frame(MODE_BUTTONS, 8'hff, 1'b0);
        queue_frame(MODE_ACCEL, 8'hff, 1'b1);
        wait_idle();

        for (int set = 0; set < 6; set++) begin
            case (set)
                0: apply_config(8'h00, 8'h00, 8'h00, 8'h00);
                1: apply_config(8'hff, 8'hff, 8'hff, 8'hff);
                2: apply_config(8'h00, 8'd200, 8'd7, 8'hff);
                3: apply_config(8'hff, 8'd3, 8'hff, 8'd1);
                default: apply_config(BYTE_W'($urandom_range(0, 255)),
                                      BYTE_W'($urandom_range(0, 255)),
                                      BYTE_W'($urandom_range(0, 255)),
                                      BYTE_W'($urandom_range(0, 255)));
            endcase
            @(negedge i_clk);
            calm = (set == 5);
            queue_random_frames(FRAMES_PER_SET);
            wait_idle();
        end

        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && frame_results_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
